// ===== hw/rtl/ptfp_pkg.sv =====
// Package for the pan/tilt frame parser.
// Holds header constants, parse phase codes and the result item type.
// No dependencies.
package ptfp_pkg;

    localparam int BYTE_W = 8;
    localparam int ERR_W  = 16;
    localparam int PAY_N  = 4;
    localparam int PHASE_W = 3;

    localparam logic [BYTE_W-1:0] HDR_FIRST  = 8'h5A;
    localparam logic [BYTE_W-1:0] HDR_SECOND = 8'hA5;

    localparam logic [PHASE_W-1:0] PH_HDR1 = 3'd0;
    localparam logic [PHASE_W-1:0] PH_HDR2 = 3'd1;
    localparam logic [PHASE_W-1:0] PH_PAY0 = 3'd2;
    localparam logic [PHASE_W-1:0] PH_PAY1 = 3'd3;
    localparam logic [PHASE_W-1:0] PH_PAY2 = 3'd4;
    localparam logic [PHASE_W-1:0] PH_PAY3 = 3'd5;
    localparam logic [PHASE_W-1:0] PH_SUM  = 3'd6;

    typedef struct packed {
        logic signed [ERR_W-1:0] pan_offset;
        logic signed [ERR_W-1:0] tilt_offset;
    } t_result;

endpackage

// ===== hw/rtl/ptfp_if.sv =====
// Valid/ready channel interfaces for the pan/tilt frame parser.
// Depends on ptfp_pkg for field widths.
interface ptfp_in_if;
    logic                           valid;
    logic                           ready;
    logic [ptfp_pkg::BYTE_W-1:0]    rx_byte;
    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface ptfp_out_if;
    logic                               valid;
    logic                               ready;
    logic signed [ptfp_pkg::ERR_W-1:0]  pan_offset;
    logic signed [ptfp_pkg::ERR_W-1:0]  tilt_offset;
    modport source (output valid, output pan_offset, output tilt_offset, input ready);
    modport sink   (input valid, input pan_offset, input tilt_offset, output ready);
endinterface

// ===== hw/rtl/ptfp_parser.sv =====
// Input byte register, parse phase tracking, payload store and checksum check.
// Depends on ptfp_pkg.
module ptfp_parser (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  logic [ptfp_pkg::BYTE_W-1:0] i_byte,
    output logic                        o_ready,
    input  logic                        i_space,
    output logic                        o_push,
    output ptfp_pkg::t_result           o_result
);

    logic                           r_in_vld;
    logic [ptfp_pkg::BYTE_W-1:0]    r_in_byte;
    logic [ptfp_pkg::PHASE_W-1:0]   r_phase;
    logic [ptfp_pkg::PHASE_W-1:0]   n_phase;
    logic [ptfp_pkg::BYTE_W-1:0]    r_pay [ptfp_pkg::PAY_N];
    logic [ptfp_pkg::BYTE_W-1:0]    sum;
    logic                           sum_ok;
    logic                           advance;

    assign advance = r_in_vld & i_space;
    assign o_ready = ~r_in_vld | i_space;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_ready) begin
            r_in_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_byte <= i_byte;
        end
    end

    // Low 8 bits of the payload sum; carries fall off.
    assign sum    = r_pay[0] + r_pay[1] + r_pay[2] + r_pay[3];
    assign sum_ok = (sum == r_in_byte);

    always_comb begin
        unique case (r_phase)
            ptfp_pkg::PH_HDR1: n_phase = (r_in_byte == ptfp_pkg::HDR_FIRST) ?
                                         ptfp_pkg::PH_HDR2 : ptfp_pkg::PH_HDR1;
            ptfp_pkg::PH_HDR2: begin
                // a repeated first header byte keeps waiting for the second
                if (r_in_byte == ptfp_pkg::HDR_SECOND) begin
                    n_phase = ptfp_pkg::PH_PAY0;
                end else if (r_in_byte == ptfp_pkg::HDR_FIRST) begin
                    n_phase = ptfp_pkg::PH_HDR2;
                end else begin
                    n_phase = ptfp_pkg::PH_HDR1;
                end
            end
            ptfp_pkg::PH_PAY0: n_phase = ptfp_pkg::PH_PAY1;
            ptfp_pkg::PH_PAY1: n_phase = ptfp_pkg::PH_PAY2;
            ptfp_pkg::PH_PAY2: n_phase = ptfp_pkg::PH_PAY3;
            ptfp_pkg::PH_PAY3: n_phase = ptfp_pkg::PH_SUM;
            default:           n_phase = ptfp_pkg::PH_HDR1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= ptfp_pkg::PH_HDR1;
        end else if (advance) begin
            r_phase <= n_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            unique case (r_phase)
                ptfp_pkg::PH_PAY0: r_pay[0] <= r_in_byte;
                ptfp_pkg::PH_PAY1: r_pay[1] <= r_in_byte;
                ptfp_pkg::PH_PAY2: r_pay[2] <= r_in_byte;
                ptfp_pkg::PH_PAY3: r_pay[3] <= r_in_byte;
                default: ;
            endcase
        end
    end

    assign o_push               = advance & (r_phase == ptfp_pkg::PH_SUM) & sum_ok;
    assign o_result.pan_offset  = {r_pay[0], r_pay[1]};
    assign o_result.tilt_offset = {r_pay[2], r_pay[3]};

endmodule

// ===== hw/rtl/ptfp_out_stage.sv =====
// Result register with one skid entry, so the parser keeps moving while a
// result waits. Depends on ptfp_pkg.
module ptfp_out_stage (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  ptfp_pkg::t_result   i_result,
    output logic                o_space,
    output logic                o_valid,
    input  logic                i_ready,
    output ptfp_pkg::t_result   o_result
);

    logic               r_out_vld;
    logic               r_sk_vld;
    ptfp_pkg::t_result  r_out;
    ptfp_pkg::t_result  r_sk;
    logic               load;

    assign o_space  = ~r_sk_vld;
    assign o_valid  = r_out_vld;
    assign o_result = r_out;
    assign load     = ~r_out_vld | i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
            r_sk_vld  <= 1'b0;
        end else if (load) begin
            r_out_vld <= r_sk_vld | i_push;
            r_sk_vld  <= 1'b0;
        end else if (i_push) begin
            r_sk_vld  <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out <= r_sk_vld ? r_sk : i_result;
        end else if (i_push) begin
            r_sk  <= i_result;
        end
    end

`ifndef SYNTHESIS
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sk_vld |-> r_out_vld)
        else $error("skid entry held without a result in the output register");

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sk_vld |-> !i_push)
        else $error("result pushed while skid entry occupied");

    a_drain_to_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && i_ready && !r_sk_vld && !i_push) |=> !r_out_vld)
        else $error("output stays valid after its last item was taken");

    a_skid_moves_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_sk_vld && i_ready) |=> (r_out_vld && !r_sk_vld))
        else $error("skid item not moved into the output register");
`endif

endmodule

// ===== hw/rtl/pan_tilt_frame_parser_core.sv =====
// Pan/tilt frame parser: finds 5A A5 framed payloads with an 8-bit additive
// checksum and emits pan and tilt errors. An accepted checksum byte is held in
// the input register; its result goes to the result register or the skid entry.
// One byte per cycle while the skid entry is free, with a combinational parse step.
// Reset (synchronous, active low) empties both stages and returns to header hunt.
module pan_tilt_frame_parser_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ptfp_in_if.sink     i_rx,
    ptfp_out_if.source  o_res
);

    logic               space;
    logic               push;
    ptfp_pkg::t_result  res_in;
    ptfp_pkg::t_result  res_out;

    ptfp_parser u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_rx.valid),
        .i_byte   (i_rx.rx_byte),
        .o_ready  (i_rx.ready),
        .i_space  (space),
        .o_push   (push),
        .o_result (res_in)
    );

    ptfp_out_stage u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_result (res_in),
        .o_space  (space),
        .o_valid  (o_res.valid),
        .i_ready  (o_res.ready),
        .o_result (res_out)
    );

    assign o_res.pan_offset  = res_out.pan_offset;
    assign o_res.tilt_offset = res_out.tilt_offset;

endmodule

// ===== sim/pan_tilt_frame_parser_core_tb.sv =====
// Testbench for pan_tilt_frame_parser_core: byte stream in, pan/tilt errors out.
// Depends on ptfp_pkg, ptfp_in_if/ptfp_out_if and the core RTL; self-checking,
// with an in-bench frame predictor and a queue of expected results.
module pan_tilt_frame_parser_core_tb;

    localparam int CLK_HALF     = 5;
    localparam int RST_CYCLES   = 5;
    localparam int RANDOM_BYTES = 1000;
    localparam int DRAIN_CYCLES = 10;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int LONG_HOLD    = 300;

    logic i_clk;
    logic i_rst_n;

    ptfp_in_if  rx_ch ();
    ptfp_out_if res_ch ();

    pan_tilt_frame_parser_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (rx_ch),
        .o_res   (res_ch)
    );

    // Frame predictor state
    logic [ptfp_pkg::PHASE_W-1:0] model_phase = ptfp_pkg::PH_HDR1;
    logic [ptfp_pkg::BYTE_W-1:0]  model_payload [ptfp_pkg::PAY_N];
    ptfp_pkg::t_result            pending_errors [$];

    int          error_count   = 0;
    int          useful_bytes  = 0;
    int unsigned cycle_count   = 0;
    bit          src_idle_en   = 1'b1;
    bit          sink_idle_en  = 1'b1;
    int          sink_hold_req = 0;

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) begin
            return 0;
        end else if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [ptfp_pkg::ERR_W-1:0] pick_error();
        case ($urandom_range(0, 9))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'hFFFF;
            3: return 16'h0000;
            default: return 16'($urandom_range(0, 16'hFFFF));
        endcase
    endfunction

    task automatic predict_byte(input logic [ptfp_pkg::BYTE_W-1:0] b);
        logic [ptfp_pkg::BYTE_W-1:0] csum;
        logic [ptfp_pkg::PHASE_W-1:0] slot;
        ptfp_pkg::t_result r;
        if (model_phase != ptfp_pkg::PH_HDR1 || b == ptfp_pkg::HDR_FIRST) begin
            useful_bytes++;
        end
        case (model_phase)
            ptfp_pkg::PH_HDR1: begin
                model_phase = (b == ptfp_pkg::HDR_FIRST) ? ptfp_pkg::PH_HDR2
                                                         : ptfp_pkg::PH_HDR1;
            end
            ptfp_pkg::PH_HDR2: begin
                if (b == ptfp_pkg::HDR_SECOND) begin
                    model_phase = ptfp_pkg::PH_PAY0;
                end else if (b == ptfp_pkg::HDR_FIRST) begin
                    model_phase = ptfp_pkg::PH_HDR2;
                end else begin
                    model_phase = ptfp_pkg::PH_HDR1;
                end
            end
            ptfp_pkg::PH_PAY0, ptfp_pkg::PH_PAY1,
            ptfp_pkg::PH_PAY2, ptfp_pkg::PH_PAY3: begin
                slot = model_phase - ptfp_pkg::PH_PAY0;
                model_payload[slot[1:0]] = b;
                model_phase = model_phase + 3'd1;
            end
            ptfp_pkg::PH_SUM: begin
                csum = model_payload[0] + model_payload[1] + model_payload[2]
                     + model_payload[3];
                if (csum == b) begin
                    r.pan_offset  = {model_payload[0], model_payload[1]};
                    r.tilt_offset = {model_payload[2], model_payload[3]};
                    pending_errors.push_back(r);
                end
                model_phase = ptfp_pkg::PH_HDR1;
            end
            default: begin
                model_phase = ptfp_pkg::PH_HDR1;
            end
        endcase
    endtask

    // Entered at a rising edge; leaves valid high on the accepting edge so a
    // back-to-back item needs no second assignment in the same step.
    task automatic send_byte(input logic [ptfp_pkg::BYTE_W-1:0] b);
        int gap;
        gap = src_idle_en ? pick_gap() : 0;
        if (gap > 0) begin
            rx_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        rx_ch.valid   <= 1'b1;
        rx_ch.rx_byte <= b;
        do @(posedge i_clk); while (!rx_ch.ready);
        predict_byte(b);
    endtask

    task automatic send_frame(input logic [ptfp_pkg::ERR_W-1:0] pan,
                              input logic [ptfp_pkg::ERR_W-1:0] tilt,
                              input logic [ptfp_pkg::BYTE_W-1:0] sum_offset);
        logic [ptfp_pkg::BYTE_W-1:0] csum;
        csum = pan[15:8] + pan[7:0] + tilt[15:8] + tilt[7:0] + sum_offset;
        send_byte(ptfp_pkg::HDR_FIRST);
        send_byte(ptfp_pkg::HDR_SECOND);
        send_byte(pan[15:8]);
        send_byte(pan[7:0]);
        send_byte(tilt[15:8]);
        send_byte(tilt[7:0]);
        send_byte(csum);
    endtask

    task automatic wait_results_drained();
        rx_ch.valid <= 1'b0;
        while (pending_errors.size() > 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Stray second header byte, broken header, repeated first header byte,
    // then a frame with the most negative pan and most positive tilt.
    task automatic test_header_hunting();
        send_byte(ptfp_pkg::HDR_SECOND);
        send_byte(ptfp_pkg::HDR_FIRST);
        send_byte(8'h00);
        send_byte(ptfp_pkg::HDR_FIRST);
        send_byte(ptfp_pkg::HDR_FIRST);
        send_frame(16'h8000, 16'h7FFF, 8'h00);
        wait_results_drained();
    endtask

    // Mismatched checksum that happens to equal the first header byte: it must
    // not start a new header, so the following A5 is plain noise.
    task automatic test_checksum_handling();
        logic [ptfp_pkg::BYTE_W-1:0] bad_sum;
        bad_sum = ptfp_pkg::HDR_FIRST - 8'h0A;
        send_frame(16'h0102, 16'h0304, bad_sum);
        send_byte(ptfp_pkg::HDR_SECOND);
        send_frame(16'hFFFF, 16'h0000, 8'h00);
        wait_results_drained();
    endtask

    // Hold the result side off while frames keep coming, so the input stalls.
    task automatic test_output_backpressure();
        src_idle_en   = 1'b0;
        sink_hold_req = LONG_HOLD;
        repeat (30) begin
            send_frame(pick_error(), pick_error(), 8'h00);
        end
        src_idle_en = 1'b1;
        wait_results_drained();
    endtask

    task automatic test_random_traffic();
        int kind;
        int n;
        logic [ptfp_pkg::BYTE_W-1:0] b;
        useful_bytes = 0;
        while (useful_bytes < RANDOM_BYTES) begin
            if ($urandom_range(0, 39) == 0) begin
                src_idle_en  = ($urandom_range(0, 3) != 0);
                sink_idle_en = ($urandom_range(0, 3) != 0);
            end
            kind = $urandom_range(0, 99);
            if (kind < 68) begin
                send_frame(pick_error(), pick_error(), 8'h00);
            end else if (kind < 77) begin
                send_frame(pick_error(), pick_error(), 8'($urandom_range(1, 255)));
            end else if (kind < 84) begin
                repeat ($urandom_range(1, 3)) send_byte(ptfp_pkg::HDR_FIRST);
                send_frame(pick_error(), pick_error(), 8'h00);
            end else if (kind < 90) begin
                send_byte(ptfp_pkg::HDR_FIRST);
                do b = 8'($urandom_range(0, 255));
                while (b == ptfp_pkg::HDR_FIRST || b == ptfp_pkg::HDR_SECOND);
                send_byte(b);
            end else if (kind < 95) begin
                // truncated frame: next bytes get absorbed as payload
                send_byte(ptfp_pkg::HDR_FIRST);
                send_byte(ptfp_pkg::HDR_SECOND);
                repeat ($urandom_range(0, 3)) send_byte(8'($urandom_range(0, 255)));
            end else begin
                n = $urandom_range(1, 6);
                repeat (n) send_byte(8'($urandom_range(0, 255)));
            end
        end
        src_idle_en  = 1'b1;
        sink_idle_en = 1'b1;
        wait_results_drained();
    endtask

    // Result side ready: random stalls, plus a counted long hold on request
    initial begin
        int stall_left;
        int hold_left;
        stall_left = 0;
        hold_left  = 0;
        res_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (sink_hold_req > 0) begin
                hold_left     = sink_hold_req;
                sink_hold_req = 0;
            end
            if (hold_left > 0) begin
                res_ch.ready <= 1'b0;
                hold_left--;
            end else if (stall_left > 0 && sink_idle_en) begin
                res_ch.ready <= 1'b0;
                stall_left--;
            end else begin
                res_ch.ready <= 1'b1;
                stall_left = 0;
                if (sink_idle_en && $urandom_range(0, 3) == 0) begin
                    stall_left = pick_gap();
                end
            end
        end
    end

    // Compare each accepted result with the oldest expectation
    initial begin
        ptfp_pkg::t_result want;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && res_ch.valid && res_ch.ready) begin
                if (pending_errors.size() == 0) begin
                    $display("%0t: unexpected result pan=%0d tilt=%0d", $time,
                             res_ch.pan_offset, res_ch.tilt_offset);
                    error_count++;
                end else begin
                    want = pending_errors.pop_front();
                    if (res_ch.pan_offset !== want.pan_offset) begin
                        $display("%0t: pan_offset expected %0d actual %0d", $time,
                                 want.pan_offset, res_ch.pan_offset);
                        error_count++;
                    end
                    if (res_ch.tilt_offset !== want.tilt_offset) begin
                        $display("%0t: tilt_offset expected %0d actual %0d", $time,
                                 want.tilt_offset, res_ch.tilt_offset);
                        error_count++;
                    end
                end
            end
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("pan_tilt_frame_parser_core test failed");
        $finish;
    end

    initial begin
        i_rst_n       <= 1'b0;
        rx_ch.valid   <= 1'b0;
        rx_ch.rx_byte <= '0;
        repeat (RST_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_header_hunting();
        test_checksum_handling();
        test_output_backpressure();
        test_random_traffic();

        if (error_count == 0 && pending_errors.size() == 0) begin
            $display("pan_tilt_frame_parser_core test passed");
        end else begin
            $display("pan_tilt_frame_parser_core test failed");
        end
        $finish;
    end

endmodule
